@@ rtl/clb_pkg.sv @@
package clb_pkg;

    localparam int TABLE_ENTRIES = 256;

    localparam logic [2:0] ACT_IDENT  = 3'd0;
    localparam logic [2:0] ACT_CLEAR  = 3'd1;
    localparam logic [2:0] ACT_APPEND = 3'd2;
    localparam logic [2:0] ACT_BUILD  = 3'd3;
    localparam logic [2:0] ACT_MAP    = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_NOPTS = 2'd2;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
    } pt_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_IDENT,
        S_APP_RD,
        S_APP_CMP,
        S_APP_PUT,
        S_BLD_INIT,
        S_BLD_FIRST,
        S_BLD_RD,
        S_BLD_CMP,
        S_BLD_M1,
        S_BLD_M2,
        S_BLD_M3,
        S_BLD_CHK,
        S_DIV,
        S_MAP_R,
        S_MAP_G,
        S_MAP_B,
        S_MAP_L,
        S_FIN
    } state_t;

    // y / 16, clamped to a byte
    function automatic logic [7:0] sat_div16(input logic [12:0] y);
        logic [8:0] q;
        q = y[12:4];
        return q[8] ? 8'hFF : q[7:0];
    endfunction

    // (a + b) / 32, clamped to a byte
    function automatic logic [7:0] sat_avg(input logic [12:0] a, input logic [12:0] b);
        logic [13:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[13] ? 8'hFF : s[12:5];
    endfunction

endpackage

@@ rtl/clb_req_if.sv @@
interface clb_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  action;
    logic [12:0] point_x;
    logic [12:0] point_y;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
    logic [7:0]  alpha_in;

    modport source (output valid, action, point_x, point_y, red_in, green_in, blue_in,
                    alpha_in, input ready);
    modport sink (input valid, action, point_x, point_y, red_in, green_in, blue_in,
                  alpha_in, output ready);
endinterface

@@ rtl/clb_rsp_if.sv @@
interface clb_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic [1:0] status;

    modport source (output valid, red_out, green_out, blue_out, alpha_out, status,
                    input ready);
    modport sink (input valid, red_out, green_out, blue_out, alpha_out, status,
                  output ready);
endinterface

@@ rtl/curves_lut_builder_and_mapper.sv @@
// Curves engine: 256-entry byte table plus a sorted store of control points.
// req carries one action per beat (identity, clear, append, build, map pixel);
// rsp returns exactly one beat per request, colors zero except for map pixel.
// One request is worked on at a time; req.ready is high only while idle.
// Work per request from accept to rsp.valid:
//   clear / unused codes / errors: straight to the finish state
//   map pixel: three reads through the single table read port
//   append: stored points with larger x move up one slot, then the point is put
//   identity: one table write per cycle
//   build: entries between points of equal x are written directly, each
//   interpolated entry passes the 8-step quotient unit, clamped entries skip it,
//   plus a point read per point passed and setup and finish states.
// Result sits in an output register; the next request is accepted while it
// waits, but its own result waits until rsp.ready drains the register.
// After reset the table is swept to identity with req.ready
// low; the point count resets to zero.
module curves_lut_builder_and_mapper
    import clb_pkg::*;
#(
    parameter int MAX_POINTS = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    clb_req_if.sink    req,
    clb_rsp_if.source  rsp
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    state_t state_reg, state_next;

    logic [7:0]  tctr_reg, tctr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic [12:0] px_reg, px_next, py_reg, py_next;
    logic [7:0]  rin_reg, rin_next, gin_reg, gin_next, bin_reg, bin_next, ain_reg, ain_next;
    logic [7:0]  res_r_reg, res_r_next, res_g_reg, res_g_next;
    logic [7:0]  res_b_reg, res_b_next, res_a_reg, res_a_next;
    logic [1:0]  res_st_reg, res_st_next;
    logic [7:0]  o_r_reg, o_r_next, o_g_reg, o_g_next, o_b_reg, o_b_next, o_a_reg, o_a_next;
    logic [1:0]  o_st_reg, o_st_next;
    logic [CW-1:0] pos_reg, pos_next, idx_reg, idx_next;
    logic [7:0]  i_reg, i_next;
    logic [12:0] lx_reg, lx_next, ly_reg, ly_next, sx_reg, sx_next, sy_reg, sy_next;
    logic [12:0] dx_reg, dx_next;
    logic signed [13:0] dy_reg, dy_next;
    logic signed [21:0] dp_reg, dp_next;
    logic [25:0] p1_reg, p1_next;
    logic signed [35:0] p2_reg, p2_next;
    logic [24:0] den_reg, den_next;
    logic signed [37:0] num_reg, num_next;
    logic [36:0] rem_reg, rem_next;
    logic [7:0]  q_reg, q_next;
    logic [2:0]  k_reg, k_next;

    logic [7:0] tab_mem [TABLE_ENTRIES];
    logic [7:0] tab_q;
    logic       tab_we;
    logic [7:0] tab_waddr, tab_wdata, tab_raddr;

    pt_t         pt_mem [MAX_POINTS];
    pt_t         pt_q;
    logic        pt_we;
    logic [AW-1:0] pt_waddr, pt_raddr;
    pt_t         pt_wdata;

    logic accept, out_free, last_i, adv, eqx, no_div, sat_hi;
    logic [CW-1:0] idx_inc, pos_dec;
    logic [20:0] sx255;
    logic [36:0] den_k;

    always_ff @(posedge clk)
    begin
        if (tab_we)
        begin
            tab_mem[tab_waddr] <= tab_wdata;
        end
        tab_q <= tab_mem[tab_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pt_we)
        begin
            pt_mem[pt_waddr] <= pt_wdata;
        end
        pt_q <= pt_mem[pt_raddr];
    end

    assign accept   = req.valid && req.ready;
    assign req.ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || rsp.ready;
    assign last_i   = (i_reg == 8'hFF);
    assign idx_inc  = idx_reg + 1'b1;
    assign pos_dec  = pos_reg - 1'b1;
    assign sx255    = {pt_q.x, 8'b0} - {8'b0, pt_q.x};
    assign adv      = sx255 < {1'b0, i_reg, 12'b0};
    assign eqx      = (pt_q.x == lx_reg);
    assign sat_hi   = num_reg >= $signed({5'b0, den_reg, 8'b0});
    assign no_div   = (num_reg <= 0) || sat_hi;
    assign den_k    = {12'b0, den_reg} << k_reg;

    assign pt_raddr = (state_reg == S_APP_RD) ? pos_dec[AW-1:0] : idx_reg[AW-1:0];
    assign tab_raddr = (state_reg == S_MAP_R) ? rin_reg :
                       (state_reg == S_MAP_G) ? gin_reg : bin_reg;

    assign rsp.valid     = out_valid_reg;
    assign rsp.red_out   = o_r_reg;
    assign rsp.green_out = o_g_reg;
    assign rsp.blue_out  = o_b_reg;
    assign rsp.alpha_out = o_a_reg;
    assign rsp.status    = o_st_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:      if (tctr_reg == 8'hFF) state_next = S_IDLE;
            S_IDLE:
            begin
                if (accept)
                begin
                    case (req.action)
                        ACT_IDENT:  state_next = S_IDENT;
                        ACT_APPEND:
                        begin
                            if (cnt_reg >= CW'(MAX_POINTS)) state_next = S_FIN;
                            else if (cnt_reg == '0)         state_next = S_APP_PUT;
                            else                            state_next = S_APP_RD;
                        end
                        ACT_BUILD:  state_next = (cnt_reg == '0) ? S_FIN : S_BLD_INIT;
                        ACT_MAP:    state_next = S_MAP_R;
                        default:    state_next = S_FIN;
                    endcase
                end
            end
            S_IDENT:     if (tctr_reg == 8'hFF) state_next = S_FIN;
            S_APP_RD:    state_next = S_APP_CMP;
            S_APP_CMP:
            begin
                if (pt_q.x > px_reg) state_next = (pos_dec == '0) ? S_APP_PUT : S_APP_RD;
                else                 state_next = S_FIN;
            end
            S_APP_PUT:   state_next = S_FIN;
            S_BLD_INIT:  state_next = S_BLD_FIRST;
            S_BLD_FIRST: state_next = (cnt_reg == CW'(1)) ? S_FIN : S_BLD_RD;
            S_BLD_RD:    state_next = S_BLD_CMP;
            S_BLD_CMP:
            begin
                if (adv)       state_next = (idx_inc == cnt_reg) ? S_FIN : S_BLD_RD;
                else if (eqx)  state_next = last_i ? S_FIN : S_BLD_CMP;
                else           state_next = S_BLD_M1;
            end
            S_BLD_M1:    state_next = S_BLD_M2;
            S_BLD_M2:    state_next = S_BLD_M3;
            S_BLD_M3:    state_next = S_BLD_CHK;
            S_BLD_CHK:
            begin
                if (no_div) state_next = last_i ? S_FIN : S_BLD_CMP;
                else        state_next = S_DIV;
            end
            S_DIV:       if (k_reg == '0) state_next = last_i ? S_FIN : S_BLD_CMP;
            S_MAP_R:     state_next = S_MAP_G;
            S_MAP_G:     state_next = S_MAP_B;
            S_MAP_B:     state_next = S_MAP_L;
            S_MAP_L:     state_next = S_FIN;
            S_FIN:       if (out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        tctr_next = tctr_reg;
        cnt_next = cnt_reg;
        out_valid_next = out_valid_reg;
        px_next = px_reg;
        py_next = py_reg;
        rin_next = rin_reg;
        gin_next = gin_reg;
        bin_next = bin_reg;
        ain_next = ain_reg;
        res_r_next = res_r_reg;
        res_g_next = res_g_reg;
        res_b_next = res_b_reg;
        res_a_next = res_a_reg;
        res_st_next = res_st_reg;
        o_r_next = o_r_reg;
        o_g_next = o_g_reg;
        o_b_next = o_b_reg;
        o_a_next = o_a_reg;
        o_st_next = o_st_reg;
        pos_next = pos_reg;
        idx_next = idx_reg;
        i_next = i_reg;
        lx_next = lx_reg;
        ly_next = ly_reg;
        sx_next = sx_reg;
        sy_next = sy_reg;
        dx_next = dx_reg;
        dy_next = dy_reg;
        dp_next = dp_reg;
        p1_next = p1_reg;
        p2_next = p2_reg;
        den_next = den_reg;
        num_next = num_reg;
        rem_next = rem_reg;
        q_next = q_reg;
        k_next = k_reg;
        tab_we = 1'b0;
        tab_waddr = i_reg;
        tab_wdata = '0;
        pt_we = 1'b0;
        pt_waddr = pos_reg[AW-1:0];
        pt_wdata = '{x: px_reg, y: py_reg};

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT, S_IDENT:
            begin
                tab_we = 1'b1;
                tab_waddr = tctr_reg;
                tab_wdata = tctr_reg;
                tctr_next = tctr_reg + 1'b1;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    px_next = req.point_x;
                    py_next = req.point_y;
                    rin_next = req.red_in;
                    gin_next = req.green_in;
                    bin_next = req.blue_in;
                    ain_next = req.alpha_in;
                    res_r_next = '0;
                    res_g_next = '0;
                    res_b_next = '0;
                    res_a_next = '0;
                    res_st_next = ST_OK;
                    tctr_next = '0;
                    pos_next = cnt_reg;
                    idx_next = '0;
                    i_next = '0;
                    case (req.action)
                        ACT_CLEAR:  cnt_next = '0;
                        ACT_APPEND: if (cnt_reg >= CW'(MAX_POINTS)) res_st_next = ST_FULL;
                        ACT_BUILD:  if (cnt_reg == '0) res_st_next = ST_NOPTS;
                        default:    ;
                    endcase
                end
            end
            S_APP_CMP:
            begin
                pt_we = 1'b1;
                if (pt_q.x > px_reg)
                begin
                    pt_wdata = pt_q;
                    pos_next = pos_dec;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_APP_PUT:
            begin
                pt_we = 1'b1;
                cnt_next = cnt_reg + 1'b1;
            end
            S_BLD_FIRST:
            begin
                lx_next = pt_q.x;
                ly_next = pt_q.y;
                idx_next = CW'(1);
            end
            S_BLD_CMP:
            begin
                if (adv)
                begin
                    lx_next = pt_q.x;
                    ly_next = pt_q.y;
                    idx_next = idx_inc;
                    if (idx_inc == cnt_reg)
                    begin
                        tab_we = 1'b1;
                        tab_wdata = sat_div16(pt_q.y);
                    end
                end
                else if (eqx)
                begin
                    tab_we = 1'b1;
                    tab_wdata = sat_avg(pt_q.y, ly_reg);
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    sx_next = pt_q.x;
                    sy_next = pt_q.y;
                end
            end
            S_BLD_M1:
            begin
                dx_next = sx_reg - lx_reg;
                dy_next = $signed({1'b0, sy_reg}) - $signed({1'b0, ly_reg});
                dp_next = $signed({2'b0, i_reg, 12'b0})
                        - $signed({1'b0, ({lx_reg, 8'b0} - {8'b0, lx_reg})});
            end
            S_BLD_M2:
            begin
                p1_next = {13'b0, ly_reg} * {13'b0, dx_reg};
                p2_next = 36'(dy_reg * dp_reg);
                den_next = {dx_reg, 12'b0} - {8'b0, dx_reg, 4'b0};
            end
            S_BLD_M3:
            begin
                num_next = $signed({4'b0, ({p1_reg, 8'b0} - {8'b0, p1_reg})})
                         + 38'(p2_reg);
            end
            S_BLD_CHK:
            begin
                rem_next = num_reg[36:0];
                q_next = '0;
                k_next = 3'd7;
                if (no_div)
                begin
                    tab_we = 1'b1;
                    tab_wdata = sat_hi ? 8'hFF : 8'h00;
                    i_next = i_reg + 1'b1;
                end
            end
            S_DIV:
            begin
                if (rem_reg >= den_k)
                begin
                    rem_next = rem_reg - den_k;
                    q_next = q_reg | (8'd1 << k_reg);
                end
                k_next = k_reg - 1'b1;
                if (k_reg == '0)
                begin
                    tab_we = 1'b1;
                    tab_wdata = (rem_reg >= den_k) ? (q_reg | 8'd1) : q_reg;
                    i_next = i_reg + 1'b1;
                end
            end
            S_MAP_G: res_r_next = tab_q;
            S_MAP_B: res_g_next = tab_q;
            S_MAP_L:
            begin
                res_b_next = tab_q;
                res_a_next = ain_reg;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    o_r_next = res_r_reg;
                    o_g_next = res_g_reg;
                    o_b_next = res_b_reg;
                    o_a_next = res_a_reg;
                    o_st_next = res_st_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            tctr_reg <= '0;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tctr_reg <= tctr_next;
            cnt_reg <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next;
        py_reg <= py_next;
        rin_reg <= rin_next;
        gin_reg <= gin_next;
        bin_reg <= bin_next;
        ain_reg <= ain_next;
        res_r_reg <= res_r_next;
        res_g_reg <= res_g_next;
        res_b_reg <= res_b_next;
        res_a_reg <= res_a_next;
        res_st_reg <= res_st_next;
        o_r_reg <= o_r_next;
        o_g_reg <= o_g_next;
        o_b_reg <= o_b_next;
        o_a_reg <= o_a_next;
        o_st_reg <= o_st_next;
        pos_reg <= pos_next;
        idx_reg <= idx_next;
        i_reg <= i_next;
        lx_reg <= lx_next;
        ly_reg <= ly_next;
        sx_reg <= sx_next;
        sy_reg <= sy_next;
        dx_reg <= dx_next;
        dy_reg <= dy_next;
        dp_reg <= dp_next;
        p1_reg <= p1_next;
        p2_reg <= p2_next;
        den_reg <= den_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
        q_reg <= q_next;
        k_reg <= k_next;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_POINTS))
        else $error("point count beyond store depth");

    a_idx_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BLD_RD || state_reg == S_BLD_CMP) |-> idx_reg < cnt_reg)
        else $error("build reads past the stored points");

    a_div_fit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < (den_k << 1))
        else $error("quotient digit overflow");

    a_fin_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> out_valid_reg && state_reg == S_IDLE)
        else $error("result not loaded into output register");

endmodule

@@ sim/tb_curves_lut_builder_and_mapper.sv @@
module tb_curves_lut_builder_and_mapper
    import clb_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPTS = 32;

    typedef struct {
        logic [7:0] r, g, b, a;
        logic [1:0] st;
    } pix_res_t;

    class curve_scoreboard;
        logic [7:0]  lut [256];
        logic [12:0] px [NPTS];
        logic [12:0] py [NPTS];
        int          npts;
        pix_res_t    pending [$];
        int          errors;

        function void init();
            for (int i = 0; i < 256; i++) lut[i] = i[7:0];
            npts = 0;
            errors = 0;
            pending.delete();
        endfunction

        function logic [7:0] clamp_div(longint num, longint den);
            longint q;
            if (den < 0)
            begin
                num = -num;
                den = -den;
            end
            if (num <= 0 || den == 0) return 8'd0;
            q = num / den;
            return (q > 255) ? 8'hFF : q[7:0];
        endfunction

        function void rebuild_lut();
            longint m, lx, ly, sx, sy, p, dx;
            int k;
            m = 255;
            k = 1;
            lx = px[0];
            ly = py[0];
            for (int i = 0; i < 256 && k < npts; i++)
            begin
                p = longint'(i) * 4096;
                while (k < npts && longint'(px[k]) * m < p)
                begin
                    lx = px[k];
                    ly = py[k];
                    k++;
                end
                if (k == npts)
                begin
                    lut[i] = clamp_div(ly, 16);
                    continue;
                end
                sx = px[k];
                sy = py[k];
                if (sx == lx)
                    lut[i] = clamp_div(sy + ly, 32);
                else
                begin
                    dx = sx - lx;
                    lut[i] = clamp_div(ly * m * dx + (sy - ly) * (p - m * lx), 16 * m * dx);
                end
            end
        endfunction

        function void note_request(logic [2:0] act, logic [12:0] x, logic [12:0] y,
                                   logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                   logic [7:0] a);
            pix_res_t e;
            int k;
            e = '{8'd0, 8'd0, 8'd0, 8'd0, ST_OK};
            case (act)
                ACT_IDENT: for (int i = 0; i < 256; i++) lut[i] = i[7:0];
                ACT_CLEAR: npts = 0;
                ACT_APPEND:
                    if (npts >= NPTS) e.st = ST_FULL;
                    else
                    begin
                        k = npts;
                        while (k > 0 && px[k-1] > x)
                        begin
                            px[k] = px[k-1];
                            py[k] = py[k-1];
                            k--;
                        end
                        px[k] = x;
                        py[k] = y;
                        npts++;
                    end
                ACT_BUILD:
                    if (npts == 0) e.st = ST_NOPTS;
                    else rebuild_lut();
                ACT_MAP:
                begin
                    e.r = lut[r];
                    e.g = lut[g];
                    e.b = lut[b];
                    e.a = a;
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        function void check_result(pix_res_t got);
            pix_res_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat r=%0d g=%0d b=%0d a=%0d st=%0d", $time,
                         got.r, got.g, got.b, got.a, got.st);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.r !== e.r || got.g !== e.g || got.b !== e.b || got.a !== e.a ||
                got.st !== e.st)
            begin
                $display("%0t: mismatch expected r=%0d g=%0d b=%0d a=%0d st=%0d", $time,
                         e.r, e.g, e.b, e.a, e.st);
                $display("%0t:          actual   r=%0d g=%0d b=%0d a=%0d st=%0d", $time,
                         got.r, got.g, got.b, got.a, got.st);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    clb_req_if req ();
    clb_rsp_if rsp ();

    curves_lut_builder_and_mapper #(.MAX_POINTS(NPTS)) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    curve_scoreboard sb;
    int  burst_left;
    int  gap_left;
    int  hold_cycles;
    int  stall_mode;
    int  beat_count;
    bit  long_hold_done;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        req.valid    = 1'b0;
        req.action   = ACT_IDENT;
        req.point_x  = '0;
        req.point_y  = '0;
        req.red_in   = '0;
        req.green_in = '0;
        req.blue_in  = '0;
        req.alpha_in = '0;
        rsp.ready    = 1'b0;
    end

    always @(posedge clk)
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_result('{rsp.red_out, rsp.green_out, rsp.blue_out, rsp.alpha_out,
                              rsp.status});

    // receiver: stall pattern plus one long hold-off
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            rsp.ready <= 1'b0;
        end
        else if (beat_count == 300 && !long_hold_done)
        begin
            hold_cycles <= 400;
            long_hold_done <= 1'b1;
            rsp.ready <= 1'b0;
        end
        else
            case (stall_mode)
                0: rsp.ready <= 1'b1;
                1: rsp.ready <= ($urandom_range(0, 3) != 0);
                default: rsp.ready <= ($urandom_range(0, 3) == 0);
            endcase
        if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
    end

    task automatic send_beat(logic [2:0] act, logic [12:0] x, logic [12:0] y,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        while (gap_left > 0)
        begin
            @(posedge clk);
            gap_left--;
        end
        req.valid    <= 1'b1;
        req.action   <= act;
        req.point_x  <= x;
        req.point_y  <= y;
        req.red_in   <= r;
        req.green_in <= g;
        req.blue_in  <= b;
        req.alpha_in <= a;
        do @(posedge clk); while (!req.ready);
        sb.note_request(act, x, y, r, g, b, a);
        beat_count++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
        if (gap_left > 0) req.valid <= 1'b0;
    endtask

    task automatic send_simple(logic [2:0] act);
        send_beat(act, 13'($urandom), 13'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom), 8'($urandom));
    endtask

    task automatic send_point(logic [12:0] x, logic [12:0] y);
        send_beat(ACT_APPEND, x, y, 8'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
        send_beat(ACT_MAP, 13'($urandom), 13'($urandom), r, g, b, a);
    endtask

    function automatic logic [12:0] rand_coord();
        case ($urandom_range(0, 7))
            0: return 13'd0;
            1: return 13'd4096;
            2: return 13'($urandom);
            default: return 13'($urandom_range(0, 4096));
        endcase
    endfunction

    initial
    begin
        sb = new();
        sb.init();
        burst_left = 0;
        gap_left = 0;
        hold_cycles = 0;
        stall_mode = 0;
        beat_count = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        send_pixel(8'd0, 8'd255, 8'd128, 8'd255);
        send_simple(ACT_BUILD);
        send_point(13'd0, 13'd4096);
        send_simple(ACT_BUILD);
        send_pixel(8'd0, 8'd1, 8'd255, 8'd0);
        send_point(13'd4096, 13'd0);
        send_point(13'd2048, 13'd8191);
        send_point(13'd2048, 13'd0);
        send_simple(ACT_BUILD);
        send_pixel(8'd0, 8'd127, 8'd128, 8'hAA);
        send_pixel(8'd129, 8'd200, 8'd255, 8'h55);
        send_simple(ACT_CLEAR);
        send_point(13'd2000, 13'd1000);
        send_point(13'd3000, 13'd8191);
        send_point(13'd8191, 13'd100);
        send_simple(ACT_BUILD);
        send_pixel(8'd10, 8'd190, 8'd250, 8'd1);
        send_simple(ACT_IDENT);
        send_pixel(8'd3, 8'd77, 8'd254, 8'd2);
        for (int i = 0; i < 30; i++) send_point(rand_coord(), rand_coord());
        send_simple(3'd5);
        send_simple(3'd6);
        send_simple(3'd7);
        send_simple(ACT_BUILD);
        send_pixel(8'd60, 8'd120, 8'd240, 8'd9);

        // random curves
        while (beat_count < 540)
        begin
            int n;
            if ($urandom_range(0, 7) == 0) send_simple(ACT_IDENT);
            send_simple(ACT_CLEAR);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(0, 6);
            for (int i = 0; i < n; i++) send_point(rand_coord(), rand_coord());
            send_simple(ACT_BUILD);
            repeat ($urandom_range(3, 14))
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            if ($urandom_range(0, 5) == 0) send_simple(3'($urandom_range(5, 7)));
        end
        req.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

endmodule
